FILE: hdl/atw_pkg.sv
// Shared types, constants and helper functions for the tare-and-weigh front end.
`default_nettype none

package atw_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 8;
  localparam int WEIGHT_W = 15;
  localparam int SUM_W    = 16;
  localparam int COUNT_W  = 4;
  localparam int QUO_W    = 12;

  // Averaging and rounding constants
  localparam int DECIM_LEN  = 10;
  localparam int ROUND_STEP = 10;
  localparam int ROUND_HALF = 5;

  // Reset gain: 9/32 grams per converter step.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd9;

  // Divide by ten through a reciprocal: floor(x * 52429 / 2^19) is exact
  // for every 16-bit x.
  localparam logic [15:0] RECIP10       = 16'hCCCD;
  localparam int          RECIP10_SHIFT = 19;

  // Word commands
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TARE   = 1'b1
  } atw_cmd_t;

  // Average and the tare it is weighed against, handed to the scaling pipe.
  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] tare;
  } atw_avg_t;

  // Quotient of a 16-bit value by ten.
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'(RECIP10);
    return prod[31:RECIP10_SHIFT];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/atw_accum.sv
// Sample accumulator, decimation by ten, last-average and tare registers.
`default_nettype none

module atw_accum
  import atw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     avg_valid,
  input  wire logic                avg_ready,
  output atw_avg_t                 avg
);

  logic [SUM_W-1:0]    sum_r;
  logic [COUNT_W-1:0]  count_r;
  logic [SAMPLE_W-1:0] last_avg_r;
  logic [SAMPLE_W-1:0] tare_r;
  logic                s1_valid_r;
  logic [SUM_W-1:0]    s1_sum_r;
  logic [SAMPLE_W-1:0] s1_tare_r;

  logic [SUM_W-1:0]    sum_add;
  logic                tenth;
  logic                accept;
  logic                load_s1;
  logic [SAMPLE_W-1:0] avg_code;
  logic [12:0]         avg_quo;

  // The decimation stage frees up whenever its word moves on.
  assign in_ready = !s1_valid_r || avg_ready;
  assign accept   = in_valid && in_ready;

  assign sum_add = sum_r + SUM_W'(in_sample);
  assign tenth   = (count_r == COUNT_W'(DECIM_LEN - 1));
  assign load_s1 = accept && (in_cmd == CMD_SAMPLE) && tenth;

  // Truncated average of the ten summed samples.
  assign avg_quo  = div10(s1_sum_r);
  assign avg_code = avg_quo[SAMPLE_W-1:0];

  // The tare travels with the average it was in force for.
  assign avg_valid   = s1_valid_r;
  assign avg.average = avg_code;
  assign avg.tare    = s1_tare_r;

  // Accumulator, decimation stage and stored averages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      count_r    <= '0;
      last_avg_r <= '0;
      tare_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s1_valid_r && avg_ready) begin
        last_avg_r <= avg_code;
      end
      // A new average fills the stage; otherwise it drains when taken.
      if (load_s1) begin
        s1_valid_r <= 1'b1;
      end else if (avg_ready) begin
        s1_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_cmd == CMD_TARE) begin
          // An average still in the decimation stage is the newest one.
          tare_r <= s1_valid_r ? avg_code : last_avg_r;
        end else if (tenth) begin
          sum_r     <= '0;
          count_r   <= '0;
          s1_sum_r  <= sum_add;
          s1_tare_r <= tare_r;
        end else begin
          sum_r   <= sum_add;
          count_r <= COUNT_W'(count_r + 1'b1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/atw_scale.sv
// Tare subtraction, gain scaling, rounding to ten grams and the result register.
`default_nettype none

module atw_scale
  import atw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                avg_valid,
  output logic                     avg_ready,
  input  wire atw_avg_t            avg,
  input  wire logic [GAIN_W-1:0]   gain,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_average_code,
  output logic [WEIGHT_W-1:0]      out_net_weight,
  output logic [WEIGHT_W-1:0]      out_rounded_weight
);

  // Stage registers
  logic                s2_valid_r;
  logic [SAMPLE_W-1:0] s2_avg_r;
  logic [SAMPLE_W-1:0] s2_tare_r;
  logic                s3_valid_r;
  logic [SAMPLE_W-1:0] s3_avg_r;
  logic [WEIGHT_W-1:0] s3_wmag_r;
  logic                s3_neg_r;
  logic                s4_valid_r;
  logic [SAMPLE_W-1:0] s4_avg_r;
  logic [WEIGHT_W-1:0] s4_wmag_r;
  logic                s4_neg_r;
  logic [QUO_W-1:0]    s4_quo_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic [WEIGHT_W-1:0] out_net_r;
  logic [WEIGHT_W-1:0] out_rnd_r;

  // Stage readiness, from the result register backward.
  logic rdy_out, rdy4, rdy3, rdy2;

  logic                neg;
  logic [SAMPLE_W-1:0] mag;
  logic [19:0]         prod;
  logic [12:0]         wquo;
  logic [WEIGHT_W-1:0] base;
  logic [WEIGHT_W-1:0] rem_full;
  logic [3:0]          rem;
  logic [WEIGHT_W-1:0] rnd;

  assign rdy_out   = !out_valid_r || out_ready;
  assign rdy4      = !s4_valid_r || rdy_out;
  assign rdy3      = !s3_valid_r || rdy4;
  assign rdy2      = !s2_valid_r || rdy3;
  assign avg_ready = rdy2;

  // Magnitude of average minus tare, times the gain, truncated by 1/32.
  assign neg  = (s2_avg_r < s2_tare_r);
  assign mag  = neg ? (s2_tare_r - s2_avg_r) : (s2_avg_r - s2_tare_r);
  assign prod = 20'(mag) * 20'(gain);

  // Quotient of the weight by ten.
  assign wquo = div10({1'b0, s3_wmag_r});

  // Remainder and rounding: above half a step rounds up.
  assign base     = WEIGHT_W'(s4_quo_r) * WEIGHT_W'(ROUND_STEP);
  assign rem_full = s4_wmag_r - base;
  assign rem      = rem_full[3:0];
  assign rnd      = (rem > 4'(ROUND_HALF)) ? (base + WEIGHT_W'(ROUND_STEP)) : base;

  // Valid bits of the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy2)    s2_valid_r  <= avg_valid;
      if (rdy3)    s3_valid_r  <= s2_valid_r;
      if (rdy4)    s4_valid_r  <= s3_valid_r;
      if (rdy_out) out_valid_r <= s4_valid_r;
    end
  end

  // Payload of the pipe.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_avg_r  <= avg.average;
      s2_tare_r <= avg.tare;
    end
    if (rdy3) begin
      s3_avg_r  <= s2_avg_r;
      s3_wmag_r <= prod[19:5];
      s3_neg_r  <= neg;
    end
    if (rdy4) begin
      s4_avg_r  <= s3_avg_r;
      s4_wmag_r <= s3_wmag_r;
      s4_neg_r  <= s3_neg_r;
      s4_quo_r  <= wquo[QUO_W-1:0];
    end
    if (rdy_out) begin
      out_avg_r <= s4_avg_r;
      out_net_r <= s4_neg_r ? '0 : s4_wmag_r;
      out_rnd_r <= s4_neg_r ? '0 : rnd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_average_code   = out_avg_r;
  assign out_net_weight     = out_net_r;
  assign out_rounded_weight = out_rnd_r;

endmodule

`default_nettype wire

FILE: hdl/adc_average_tare_weigh_top.sv
// Top level of the weighing-scale front end: gain register and the two pipe halves.
`default_nettype none

// Weighing-scale front end. Each sample word adds a 12-bit converter code to
// a running sum; every tenth sample produces one result word carrying the
// truncated average, the net weight ((average - tare) * gain / 32, truncated,
// clamped at zero) and that weight rounded to ten. A tare word copies the
// latest average into the tare register and produces no result. One word is
// taken every cycle while out_ready does not hold the pipe; a result passes
// through the decimation register, stages s2, s3 and s4 and the result
// register, and the divide by ten, the gain product and the rounding quotient
// each feed a register. Write the gain only while no word is in flight.

module adc_average_tare_weigh_top
  import atw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [GAIN_W-1:0]   cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_average_code,
  output logic [WEIGHT_W-1:0]      out_net_weight,
  output logic [WEIGHT_W-1:0]      out_rounded_weight
);

  logic [GAIN_W-1:0] gain_r;
  logic              avg_valid;
  logic              avg_ready;
  atw_avg_t          avg;

  // Gain register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  atw_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_sample (in_sample),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg       (avg)
  );

  atw_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .avg_valid          (avg_valid),
    .avg_ready          (avg_ready),
    .avg                (avg),
    .gain               (gain_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_average_code   (out_average_code),
    .out_net_weight     (out_net_weight),
    .out_rounded_weight (out_rounded_weight)
  );

endmodule

`default_nettype wire
